>>> rtl/sct_pkg.sv
// Shared types, codes and constants of the sleep cycle table.
`timescale 1ns / 1ps

package sct_pkg;

  localparam int MAX_TREES_DEF = 256;
  localparam int ENTRY_W       = 9;
  localparam int TREE_W        = 8;
  localparam int TC_W          = 9;
  localparam int MAS_W         = 8;
  localparam int CFG_IDX_W     = 4;
  localparam int IN_TDATA_W    = 32;
  localparam int OUT_TDATA_W   = 32;

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic [2:0]                action_t;
  typedef logic [2:0]                status_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  localparam action_t ACT_READ     = 3'd0;
  localparam action_t ACT_WRITE    = 3'd1;
  localparam action_t ACT_TICK     = 3'd2;
  localparam action_t ACT_WAKE     = 3'd3;
  localparam action_t ACT_CMIN     = 3'd4;
  localparam action_t ACT_MEMBER   = 3'd5;
  localparam action_t ACT_WAKE_ALL = 3'd6;

  localparam status_t STS_OK        = 3'd0;
  localparam status_t STS_RANGE     = 3'd1;
  localparam status_t STS_BAD_LINK  = 3'd2;
  localparam status_t STS_NOT_CYCLE = 3'd3;
  localparam status_t STS_ASLEEP    = 3'd4;
  localparam status_t STS_NOT_READY = 3'd5;

  localparam cfg_idx_t CFG_TREE_COUNT = 4'd0;
  localparam cfg_idx_t CFG_MIN_AWAKE  = 4'd1;

  localparam logic [TC_W-1:0]  TREE_COUNT_RESET = 9'd256;
  localparam logic [MAS_W-1:0] MIN_AWAKE_RESET  = 8'd10;
  localparam entry_t           RESET_AWAKE      = entry_t'(~{1'b0, MIN_AWAKE_RESET});
  localparam entry_t           MINUS_ONE        = entry_t'(-1);

  typedef struct packed {
    logic clear;
    logic load;
    logic exec;
    logic walk;
    logic wpass;
    logic sweep;
    logic memb2;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic go_walk;
    logic go_sweep;
    logic go_memb2;
    logic walk_end;
    logic walk_to_wpass;
    logic wpass_done;
    logic sweep_done;
  } sts_t;

endpackage

>>> rtl/sleep_cycle_table.sv
// Top level of the sleep cycle table: configuration, controller and datapath.
//
//   channel  direction  ports                                    width of data
//   in       slave      in_tvalid in_tready in_tdata in_tuser    32 + 3 + tlast
//   out      master     out_tvalid out_tready out_tdata          32
//   cfg      slave      cfg_valid cfg_ready cfg_index cfg_data   4 + 9
//
// For read, write, tick and a wake of an awake entry, the accept cycle issues the
// table read and the execute state does the modify-write. A sleep member that needs
// two link writes does the second one in the MEMB2 state. Cycle min and a wake of a
// sleeping cycle walk the cycle through the single memory read port (one link a
// cycle), and the wake then makes a second pass that writes each member. Wake all
// sweeps the effective tree count, one entry a cycle. After reset a clearing pass
// fills the table while in_tready stays low; configuration beats are taken throughout.
// A result waiting in the output register does not hold off the next input beat.
`timescale 1ns / 1ps

module sleep_cycle_table #(
  parameter int MAX_TREES = sct_pkg::MAX_TREES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: tree[7:0], may_rest[8], wake_value[17:9], write_value[26:18], zeros
  input  logic [sct_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: action[2:0]
  input  sct_pkg::action_t                 in_tuser,
  input  logic                             in_tlast,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // out_tdata: entry_value[8:0], woke_count[17:9], cycle_first[25:18],
  // ready_to_sleep[26], status[29:27], zeros
  output logic [sct_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  sct_pkg::cfg_idx_t                cfg_index,
  input  logic [sct_pkg::TC_W-1:0]         cfg_data
);

  localparam int CNT_W = $clog2(MAX_TREES + 1);

  logic [CNT_W-1:0] cnt;
  sct_pkg::entry_t  awake;
  sct_pkg::cmd_t    cmd;
  sct_pkg::sts_t    sts;

  assign cfg_ready = 1'b1;

  sct_cfg #(.MAX_TREES(MAX_TREES)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cnt       (cnt),
    .awake     (awake)
  );

  sct_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sct_dp #(.MAX_TREES(MAX_TREES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cnt       (cnt),
    .awake     (awake),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

  a_one_beat_per_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input beat accepted in the cycle after an accept");

  a_error_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[29:27] != sct_pkg::STS_OK) |->
      (out_tdata[17:9] == '0) && (out_tdata[25:18] == '0))
    else $error("woke_count or cycle_first set on an error result");

  a_ready_matches_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[26] == (out_tdata[8:0] == 9'h1FF))
    else $error("ready_to_sleep disagrees with entry_value");

endmodule

>>> rtl/sct_cfg.sv
// Configuration registers: tree count with its clamped effective count and awake value.
`timescale 1ns / 1ps

module sct_cfg #(
  parameter int MAX_TREES = sct_pkg::MAX_TREES_DEF,
  localparam int CNT_W = $clog2(MAX_TREES + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  sct_pkg::cfg_idx_t              cfg_index,
  input  logic [sct_pkg::TC_W-1:0]       cfg_data,
  output logic [CNT_W-1:0]               cnt,
  output sct_pkg::entry_t                awake
);

  localparam int CW = (CNT_W > sct_pkg::TC_W) ? CNT_W : sct_pkg::TC_W;

  logic [sct_pkg::TC_W-1:0]  tc_r,  tc_nxt;
  logic [sct_pkg::MAS_W-1:0] mas_r, mas_nxt;
  logic [CW-1:0]             tc_w;

  always_comb begin
    tc_nxt  = tc_r;
    mas_nxt = mas_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sct_pkg::CFG_TREE_COUNT: tc_nxt  = cfg_data;
        sct_pkg::CFG_MIN_AWAKE:  mas_nxt = cfg_data[sct_pkg::MAS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r  <= sct_pkg::TREE_COUNT_RESET;
      mas_r <= sct_pkg::MIN_AWAKE_RESET;
    end else begin
      tc_r  <= tc_nxt;
      mas_r <= mas_nxt;
    end
  end

  assign tc_w = CW'(tc_r);

  always_comb begin
    if (tc_w == '0) begin
      cnt = CNT_W'(1);
    end else if (tc_w > CW'(MAX_TREES)) begin
      cnt = CNT_W'(MAX_TREES);
    end else begin
      cnt = CNT_W'(tc_w);
    end
  end

  assign awake = sct_pkg::entry_t'(~{1'b0, mas_r});

endmodule

>>> rtl/sct_dp.sv
// Datapath: entry memory, item and result registers, cycle walk and sweep logic.
`timescale 1ns / 1ps

module sct_dp #(
  parameter int MAX_TREES = sct_pkg::MAX_TREES_DEF,
  localparam int IDX_W = $clog2(MAX_TREES),
  localparam int CNT_W = $clog2(MAX_TREES + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [sct_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  sct_pkg::action_t                  in_tuser,
  input  logic                              in_tlast,
  input  logic [CNT_W-1:0]                  cnt,
  input  sct_pkg::entry_t                   awake,
  input  sct_pkg::cmd_t                     cmd,
  output sct_pkg::sts_t                     sts,
  output logic [sct_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int CW = (CNT_W > sct_pkg::ENTRY_W) ? CNT_W : sct_pkg::ENTRY_W;
  localparam int TW = sct_pkg::TREE_W;

  sct_pkg::entry_t mem [MAX_TREES];
  sct_pkg::entry_t rdata_r;
  logic            rd_en, we;
  logic [IDX_W-1:0] raddr, waddr;
  sct_pkg::entry_t wdata;

  sct_pkg::action_t act_r;
  logic [TW-1:0]    tree_r;
  logic             can_r, last_r;
  sct_pkg::entry_t  wv_r, wrv_r;

  sct_pkg::entry_t  ev_r, ev_nxt;
  logic [8:0]       woke_r, woke_nxt;
  logic [TW-1:0]    first_r, first_nxt;
  sct_pkg::status_t status_r, status_nxt;

  logic [TW-1:0]    cur_r, cur_nxt, small_r, small_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt, ptr_r, ptr_nxt, steps_inc;
  logic             pend_r, pend_nxt;
  logic             gopen_r, gopen_nxt;
  logic [TW-1:0]    gfirst_r, gfirst_nxt, gprev_r, gprev_nxt;

  logic [sct_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  logic [TW-1:0]    tree_in, nx8, small_new;
  logic             inr, link_bad, link_home, walk_full, issuing, e_ok;
  sct_pkg::entry_t  wvs;

  assign tree_in   = in_tdata[7:0];
  assign inr       = CW'(tree_r) < CW'(cnt);
  assign wvs       = wv_r[sct_pkg::ENTRY_W-1] ? wv_r : sct_pkg::MINUS_ONE;
  assign nx8       = rdata_r[TW-1:0];
  assign link_bad  = rdata_r[sct_pkg::ENTRY_W-1] || (CW'(nx8) >= CW'(cnt));
  assign link_home = nx8 == tree_r;
  assign steps_inc = CNT_W'(steps_r + 1'b1);
  assign walk_full = steps_inc == cnt;
  assign issuing   = ptr_r < cnt;
  assign e_ok      = rdata_r == sct_pkg::MINUS_ONE;
  assign small_new = (nx8 < small_r) ? nx8 : small_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_comb begin
    sct_pkg::entry_t nv;
    sct_pkg::entry_t w1data;
    logic            w1, w2;
    logic [TW-1:0]   gf_new;
    nv         = rdata_r;
    w1data     = '0;
    w1         = 1'b0;
    w2         = 1'b0;
    gf_new     = gfirst_r;
    rd_en      = 1'b0;
    raddr      = IDX_W'(tree_in);
    we         = 1'b0;
    waddr      = IDX_W'(tree_r);
    wdata      = awake;
    sts        = '0;
    ev_nxt     = ev_r;
    woke_nxt   = woke_r;
    first_nxt  = first_r;
    status_nxt = status_r;
    cur_nxt    = cur_r;
    steps_nxt  = steps_r;
    small_nxt  = small_r;
    ptr_nxt    = ptr_r;
    pend_nxt   = pend_r;
    gopen_nxt  = gopen_r;
    gfirst_nxt = gfirst_r;
    gprev_nxt  = gprev_r;

    if (cmd.clear) begin
      we             = 1'b1;
      waddr          = ptr_r[IDX_W-1:0];
      wdata          = sct_pkg::RESET_AWAKE;
      ptr_nxt        = CNT_W'(ptr_r + 1'b1);
      sts.clear_done = ptr_r == CNT_W'(MAX_TREES - 1);
    end else if (cmd.load) begin
      rd_en      = 1'b1;
      raddr      = IDX_W'(tree_in);
      cur_nxt    = tree_in;
      small_nxt  = tree_in;
      steps_nxt  = '0;
      ptr_nxt    = '0;
      pend_nxt   = 1'b0;
      ev_nxt     = '0;
      woke_nxt   = '0;
      first_nxt  = '0;
      status_nxt = sct_pkg::STS_OK;
    end else if (cmd.exec) begin
      if (act_r == sct_pkg::ACT_WAKE_ALL) begin
        sts.go_sweep = 1'b1;
      end else if (!inr) begin
        status_nxt = sct_pkg::STS_RANGE;
      end else begin
        ev_nxt = rdata_r;
        unique case (act_r)
          sct_pkg::ACT_WRITE: begin
            we     = 1'b1;
            wdata  = wrv_r;
            ev_nxt = wrv_r;
          end
          sct_pkg::ACT_TICK: begin
            if (rdata_r[sct_pkg::ENTRY_W-1]) begin
              if (!can_r) begin
                nv = awake;
              end else if (rdata_r < sct_pkg::MINUS_ONE) begin
                nv = sct_pkg::entry_t'(rdata_r + 9'sd1);
              end else begin
                nv = rdata_r;
              end
              we     = 1'b1;
              wdata  = nv;
              ev_nxt = nv;
            end
          end
          sct_pkg::ACT_WAKE: begin
            if (rdata_r[sct_pkg::ENTRY_W-1]) begin
              nv     = (wvs < rdata_r) ? wvs : rdata_r;
              we     = 1'b1;
              wdata  = nv;
              ev_nxt = nv;
            end else begin
              sts.go_walk = 1'b1;
            end
          end
          sct_pkg::ACT_CMIN: begin
            sts.go_walk = 1'b1;
          end
          sct_pkg::ACT_MEMBER: begin
            if (e_ok) begin
              w1         = gopen_r;
              w1data     = sct_pkg::entry_t'({1'b0, tree_r});
              gf_new     = gopen_r ? gfirst_r : tree_r;
              gfirst_nxt = gf_new;
              gprev_nxt  = tree_r;
              w2         = last_r;
              gopen_nxt  = !last_r;
            end else begin
              status_nxt = rdata_r[sct_pkg::ENTRY_W-1] ? sct_pkg::STS_NOT_READY
                                                       : sct_pkg::STS_ASLEEP;
              w1         = last_r && gopen_r;
              w1data     = sct_pkg::entry_t'({1'b0, gfirst_r});
              if (w1) begin
                gopen_nxt = 1'b0;
              end
            end
            we           = w1 || w2;
            waddr        = w1 ? IDX_W'(gprev_r) : IDX_W'(tree_r);
            wdata        = w1 ? w1data : sct_pkg::entry_t'({1'b0, gf_new});
            sts.go_memb2 = w1 && w2;
            if (w2) begin
              ev_nxt = sct_pkg::entry_t'({1'b0, gf_new});
            end else if (w1 && (gprev_r == tree_r)) begin
              ev_nxt = w1data;
            end
          end
          default: ;
        endcase
      end
    end else if (cmd.walk) begin
      rd_en        = 1'b1;
      sts.walk_end = link_bad || link_home || walk_full;
      if (link_bad) begin
        status_nxt = sct_pkg::STS_BAD_LINK;
      end else if (link_home) begin
        if (act_r == sct_pkg::ACT_CMIN) begin
          first_nxt = small_new;
        end else begin
          woke_nxt          = 9'(steps_inc);
          ev_nxt            = wvs;
          sts.walk_to_wpass = 1'b1;
          raddr             = IDX_W'(tree_r);
          cur_nxt           = tree_r;
        end
      end else if (walk_full) begin
        status_nxt = sct_pkg::STS_NOT_CYCLE;
      end else begin
        raddr     = IDX_W'(nx8);
        cur_nxt   = nx8;
        steps_nxt = steps_inc;
        small_nxt = small_new;
      end
    end else if (cmd.wpass) begin
      we    = 1'b1;
      waddr = IDX_W'(cur_r);
      wdata = wvs;
      if (link_home) begin
        sts.wpass_done = 1'b1;
      end else begin
        rd_en   = 1'b1;
        raddr   = IDX_W'(nx8);
        cur_nxt = nx8;
      end
    end else if (cmd.sweep) begin
      if (issuing) begin
        rd_en   = 1'b1;
        raddr   = ptr_r[IDX_W-1:0];
        we      = 1'b1;
        waddr   = ptr_r[IDX_W-1:0];
        wdata   = awake;
        ptr_nxt = CNT_W'(ptr_r + 1'b1);
      end
      pend_nxt = issuing;
      if (pend_r && !rdata_r[sct_pkg::ENTRY_W-1]) begin
        woke_nxt = 9'(woke_r + 1'b1);
      end
      sts.sweep_done = !issuing && !pend_r;
      if (sts.sweep_done) begin
        ev_nxt = inr ? awake : '0;
      end
    end else if (cmd.memb2) begin
      we    = 1'b1;
      waddr = IDX_W'(tree_r);
      wdata = sct_pkg::entry_t'({1'b0, gfirst_r});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_tuser;
      tree_r <= tree_in;
      can_r  <= in_tdata[8];
      wv_r   <= sct_pkg::entry_t'(in_tdata[17:9]);
      wrv_r  <= sct_pkg::entry_t'(in_tdata[26:18]);
      last_r <= in_tlast;
    end
    ev_r     <= ev_nxt;
    woke_r   <= woke_nxt;
    first_r  <= first_nxt;
    status_r <= status_nxt;
    cur_r    <= cur_nxt;
    steps_r  <= steps_nxt;
    small_r  <= small_nxt;
    if (cmd.out_load) begin
      out_tdata_r <= {2'b00, status_nxt, ev_nxt == sct_pkg::MINUS_ONE, first_nxt,
                      woke_nxt, ev_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      pend_r   <= 1'b0;
      gopen_r  <= 1'b0;
      gfirst_r <= '0;
      gprev_r  <= '0;
    end else begin
      ptr_r    <= ptr_nxt;
      pend_r   <= pend_nxt;
      gopen_r  <= gopen_nxt;
      gfirst_r <= gfirst_nxt;
      gprev_r  <= gprev_nxt;
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

>>> rtl/sct_ctrl.sv
// Controller state machine: sequences the datapath and owns both handshakes.
`timescale 1ns / 1ps

module sct_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  sct_pkg::sts_t sts,
  output sct_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_EXEC   = 8'b0000_0100,
    S_WALK   = 8'b0000_1000,
    S_WPASS  = 8'b0001_0000,
    S_SWEEP  = 8'b0010_0000,
    S_MEMB2  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   out_free;

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.go_sweep) begin
          state_nxt = S_SWEEP;
        end else if (sts.go_walk) begin
          state_nxt = S_WALK;
        end else if (sts.go_memb2) begin
          state_nxt = S_MEMB2;
        end else if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_end) begin
          state_nxt = sts.walk_to_wpass ? S_WPASS : S_FINISH;
        end
      end
      S_WPASS: begin
        cmd.wpass = 1'b1;
        if (sts.wpass_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_MEMB2: begin
        cmd.memb2 = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_tvalid_r;

endmodule
